FILE: src/lrc_pkg.sv
// Package for the label run counter: field widths, configuration register
// indexes, parameter defaults and the configuration write bundle.
// No dependencies.
package lrc_pkg;

	// Parameter defaults
	localparam int NULL_SLOTS_DEF = 4;
	localparam int COUNT_BITS_DEF = 20;

	// Field widths
	localparam int LABEL_W    = 16;
	localparam int OUT_W      = 20;
	localparam int NCOUNT_W   = 3;
	localparam int S_TDATA_W  = 16;
	localparam int M_TDATA_W  = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NULL_A     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NULL_B     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NULL_C     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NULL_D     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NULL_COUNT = 3'd4;

	// Null slot registers in index order a, b, c, d
	localparam logic [CFG_IDX_W-1:0] REG_OF_SLOT [4] = '{
		REG_NULL_A, REG_NULL_B, REG_NULL_C, REG_NULL_D
	};

	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

endpackage

FILE: src/label_run_counter_unit.sv
// Label run counter top level: input register, run tracker, null match and
// result register. Depends on lrc_pkg, lrc_null_match and lrc_run_track.
// Path: a last sample is held in the input register, then its count is registered in the result register on m_tvalid.
// Throughput: one sample per cycle; a last sample waits in the input register only
// while the previous count is still held in the result register.
// Reset (arst_n low, asynchronous): clears the run state, both valid flags and all
// configuration registers.
module label_run_counter_unit #(
	parameter int NULL_SLOTS = lrc_pkg::NULL_SLOTS_DEF,
	parameter int COUNT_BITS = lrc_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// sample stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [lrc_pkg::S_TDATA_W-1:0]   s_tdata,   // [15:0] label
	input  logic                            s_tlast,   // last sample of the dataset
	// count stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [lrc_pkg::M_TDATA_W-1:0]   m_tdata,   // [19:0] instance_count, [23:20] zero
	// configuration writes
	input  logic                            cfg_we,
	input  logic [lrc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [lrc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import lrc_pkg::*;

	// input register
	logic                      valid_s1;
	logic                      last_s1;
	logic signed [LABEL_W-1:0] label_s1;

	// result register
	logic              out_valid_s2;
	logic [OUT_W-1:0]  out_count_s2;

	logic                            advance;
	logic                            is_null;
	logic signed [LABEL_W-1:0]       run_label;
	logic [COUNT_BITS-1:0]           total_next;
	logic [COUNT_BITS+OUT_W-1:0]     total_wide;
	cfg_wr_t                         cfg;

	assign cfg = '{we: cfg_we, idx: cfg_idx, data: cfg_data};

	// A sample that ends no dataset never touches the result register, so it
	// advances regardless of the output side. A last sample needs the result
	// register free or being drained in this cycle.
	assign advance  = valid_s1 && (!last_s1 || !out_valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// hold the sample while it waits on the result register
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			label_s1 <= s_tdata[LABEL_W-1:0];
			last_s1  <= s_tlast;
		end
	end

	lrc_null_match #(
		.NULL_SLOTS(NULL_SLOTS)
	) u_null (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.probe  (run_label),
		.is_null(is_null)
	);

	lrc_run_track #(
		.COUNT_BITS(COUNT_BITS)
	) u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (advance),
		.label      (label_s1),
		.last_sample(last_s1),
		.is_null    (is_null),
		.run_label  (run_label),
		.total_next (total_next)
	);

	// fit the count to the output field: zero-extend or drop the high bits
	assign total_wide = {{OUT_W{1'b0}}, total_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_count_s2 <= total_wide[OUT_W-1:0];
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = {(M_TDATA_W - OUT_W)'(0), out_count_s2};

	// a last sample that leaves the input register always produces a count
	a_last_gives_count: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> m_tvalid)
		else $error("last sample advanced without a count");

	// a sample that cannot advance stays in the input register unchanged
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(label_s1) && $stable(last_s1)))
		else $error("stalled sample lost or altered");

	// a held count is never overwritten before its transfer
	a_count_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !(advance && last_s1))
		else $error("held count overwritten");

endmodule

FILE: src/lrc_null_match.sv
// Null label registers and the match against one label.
// Depends on lrc_pkg.
module lrc_null_match #(
	parameter int NULL_SLOTS = lrc_pkg::NULL_SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lrc_pkg::cfg_wr_t             cfg,
	input  logic signed [lrc_pkg::LABEL_W-1:0] probe,
	output logic                         is_null
);
	import lrc_pkg::*;

	localparam logic [NCOUNT_W-1:0] SLOTS_C = NCOUNT_W'(NULL_SLOTS);

	logic [LABEL_W-1:0]  null_label_q [NULL_SLOTS];
	logic [NCOUNT_W-1:0] null_count_q;
	logic [NCOUNT_W-1:0] used;
	logic [NULL_SLOTS-1:0] hit;

	for (genvar i = 0; i < NULL_SLOTS; i++) begin : g_slot
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				null_label_q[i] <= '0;
			end else if (cfg.we && cfg.idx == REG_OF_SLOT[i]) begin
				null_label_q[i] <= cfg.data[LABEL_W-1:0];
			end
		end

		assign hit[i] = (NCOUNT_W'(i) < used) && (null_label_q[i] == probe);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			null_count_q <= '0;
		end else if (cfg.we && cfg.idx == REG_NULL_COUNT) begin
			null_count_q <= cfg.data[NCOUNT_W-1:0];
		end
	end

	// clamp the slot count to the slots built
	assign used    = (null_count_q > SLOTS_C) ? SLOTS_C : null_count_q;
	assign is_null = |hit;

endmodule

FILE: src/lrc_run_track.sv
// Run tracking state: previous label, open run, saturating run total.
// Depends on lrc_pkg; the null decision comes from lrc_null_match.
module lrc_run_track #(
	parameter int COUNT_BITS = lrc_pkg::COUNT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               step_en,
	input  logic signed [lrc_pkg::LABEL_W-1:0] label,
	input  logic                               last_sample,
	input  logic                               is_null,
	output logic signed [lrc_pkg::LABEL_W-1:0] run_label,
	output logic [COUNT_BITS-1:0]              total_next
);
	import lrc_pkg::*;

	logic                      have_prev_q;
	logic                      run_open_q;
	logic signed [LABEL_W-1:0] prev_label_q;
	logic signed [LABEL_W-1:0] run_label_q;
	logic [COUNT_BITS-1:0]     run_total_q;
	logic                      differ;
	logic                      close_run;
	logic                      incr;

	// the run in force: an open run, or the one that opens on the previous sample
	assign run_label  = run_open_q ? run_label_q : prev_label_q;
	assign differ     = (label != run_label);
	assign close_run  = have_prev_q && (differ || last_sample);
	assign incr       = close_run && !is_null && !(&run_total_q);
	assign total_next = run_total_q + COUNT_BITS'(incr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			run_open_q  <= 1'b0;
			run_total_q <= '0;
		end else if (step_en) begin
			if (last_sample) begin
				have_prev_q <= 1'b0;
				run_open_q  <= 1'b0;
				run_total_q <= '0;
			end else begin
				have_prev_q <= 1'b1;
				run_open_q  <= have_prev_q && !differ;
				run_total_q <= total_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			prev_label_q <= label;
			if (have_prev_q) begin
				run_label_q <= run_label;
			end
		end
	end

endmodule
